[design/beacon_steering_drive_top_macros.svh]
// ============================================================================
// beacon_steering_drive_top_macros: assertion helpers
// Concurrent assertion shorthands clocked on clk, disabled while rst_n is low.
// ============================================================================
`ifndef BEACON_STEERING_DRIVE_TOP_MACROS_SVH
`define BEACON_STEERING_DRIVE_TOP_MACROS_SVH

// same-cycle implication
`define BSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bsd_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// bsd_pkg: beacon steering drive shared definitions
// Widths, register codes, reset values and the types passed between modules.
// ============================================================================
package bsd_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int SENSOR_COUNT   = 8;
    localparam int IDX_BITS       = $clog2(SENSOR_COUNT);
    localparam int SUM_BITS       = SAMPLE_BITS + IDX_BITS;
    localparam int LEVEL_BITS     = 13;
    localparam int GAIN_BITS      = 7;
    localparam int DRIVE_BITS     = 8;
    localparam int CALC_BITS      = 11;
    localparam int ERR_BITS       = 4;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 13;

    localparam logic [IDX_BITS-1:0]         CENTER_SENSOR = IDX_BITS'(4);
    localparam logic signed [CALC_BITS-1:0] DRIVE_MAX     = CALC_BITS'(127);
    localparam logic signed [CALC_BITS-1:0] DRIVE_MIN     = -CALC_BITS'(127);

    localparam logic [LEVEL_BITS-1:0] AMBIENT_RESET = LEVEL_BITS'(200);
    localparam logic [LEVEL_BITS-1:0] SLOW_RESET    = LEVEL_BITS'(5000);
    localparam logic [LEVEL_BITS-1:0] STOP_RESET    = LEVEL_BITS'(6000);
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET    = GAIN_BITS'(20);
    localparam logic [GAIN_BITS-1:0]  CRUISE_RESET  = GAIN_BITS'(70);
    localparam logic [GAIN_BITS-1:0]  NEAR_RESET    = GAIN_BITS'(40);
    localparam logic [GAIN_BITS-1:0]  SPIN_RESET    = GAIN_BITS'(45);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_AMBIENT = 3'd0,
        CFG_SLOW    = 3'd1,
        CFG_STOP    = 3'd2,
        CFG_GAIN    = 3'd3,
        CFG_CRUISE  = 3'd4,
        CFG_NEAR    = 3'd5,
        CFG_SPIN    = 3'd6
    } cfg_index_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_TRACK  = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_NEAR   = 2'd2,
        MODE_STOP   = 2'd3
    } drive_mode_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t frame_t [SENSOR_COUNT];

    typedef struct packed {
        logic [LEVEL_BITS-1:0] dark_thresh;
        logic [LEVEL_BITS-1:0] near_thresh;
        logic [LEVEL_BITS-1:0] halt_thresh;
        logic [GAIN_BITS-1:0]  steer_gain;
        logic [GAIN_BITS-1:0]  cruise_speed;
        logic [GAIN_BITS-1:0]  near_speed;
        logic [GAIN_BITS-1:0]  search_spin;
    } cfg_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] total;
        logic [IDX_BITS-1:0] index;
    } stats_t;

    typedef struct packed {
        logic signed [DRIVE_BITS-1:0] left_drive;
        logic signed [DRIVE_BITS-1:0] right_drive;
        logic [SUM_BITS-1:0]          total_intensity;
        logic [IDX_BITS-1:0]          brightest_index;
        drive_mode_t                  drive_mode;
    } result_t;

endpackage

[design/bsd_ifs.sv]
`timescale 1ns / 1ps
// ============================================================================
// bsd_ifs: beacon steering drive channels
// Valid/ready channels for sensor frames, drive results and register writes.
// ============================================================================
interface bsd_frame_if;
    logic                    valid;
    logic                    ready;
    logic [bsd_pkg::SAMPLE_BITS-1:0] intensity_0;
    logic [bsd_pkg::SAMPLE_BITS-1:0] intensity_1;
    logic [bsd_pkg::SAMPLE_BITS-1:0] intensity_2;
    logic [bsd_pkg::SAMPLE_BITS-1:0] intensity_3;
    logic [bsd_pkg::SAMPLE_BITS-1:0] intensity_4;
    logic [bsd_pkg::SAMPLE_BITS-1:0] intensity_5;
    logic [bsd_pkg::SAMPLE_BITS-1:0] intensity_6;
    logic [bsd_pkg::SAMPLE_BITS-1:0] intensity_7;

    modport source (
        output valid, intensity_0, intensity_1, intensity_2, intensity_3,
               intensity_4, intensity_5, intensity_6, intensity_7,
        input  ready
    );
    modport sink (
        input  valid, intensity_0, intensity_1, intensity_2, intensity_3,
               intensity_4, intensity_5, intensity_6, intensity_7,
        output ready
    );
endinterface

interface bsd_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bsd_pkg::DRIVE_BITS-1:0] left_drive;
    logic signed [bsd_pkg::DRIVE_BITS-1:0] right_drive;
    logic [bsd_pkg::SUM_BITS-1:0]          total_intensity;
    logic [bsd_pkg::IDX_BITS-1:0]          brightest_index;
    logic [bsd_pkg::MODE_BITS-1:0]         drive_mode;

    modport source (
        output valid, left_drive, right_drive, total_intensity, brightest_index,
               drive_mode,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, total_intensity, brightest_index,
               drive_mode,
        output ready
    );
endinterface

interface bsd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bsd_pkg::CFG_INDEX_BITS-1:0] index;
    logic [bsd_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/bsd_cfg_regs.sv]
`timescale 1ns / 1ps
// ============================================================================
// bsd_cfg_regs: configuration register file
// Decodes register writes; out-of-range indexes are dropped.
// ============================================================================
module bsd_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    bsd_cfg_if.sink         cfg,
    output bsd_pkg::cfg_t   regs
);

    bsd_pkg::cfg_t cfg_reg;
    bsd_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                bsd_pkg::CFG_AMBIENT:
                    cfg_next.dark_thresh = cfg.data[bsd_pkg::LEVEL_BITS-1:0];
                bsd_pkg::CFG_SLOW:
                    cfg_next.near_thresh = cfg.data[bsd_pkg::LEVEL_BITS-1:0];
                bsd_pkg::CFG_STOP:
                    cfg_next.halt_thresh = cfg.data[bsd_pkg::LEVEL_BITS-1:0];
                bsd_pkg::CFG_GAIN:
                    cfg_next.steer_gain = cfg.data[bsd_pkg::GAIN_BITS-1:0];
                bsd_pkg::CFG_CRUISE:
                    cfg_next.cruise_speed = cfg.data[bsd_pkg::GAIN_BITS-1:0];
                bsd_pkg::CFG_NEAR:
                    cfg_next.near_speed = cfg.data[bsd_pkg::GAIN_BITS-1:0];
                bsd_pkg::CFG_SPIN:
                    cfg_next.search_spin = cfg.data[bsd_pkg::GAIN_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_thresh   <= bsd_pkg::AMBIENT_RESET;
            cfg_reg.near_thresh   <= bsd_pkg::SLOW_RESET;
            cfg_reg.halt_thresh   <= bsd_pkg::STOP_RESET;
            cfg_reg.steer_gain    <= bsd_pkg::GAIN_RESET;
            cfg_reg.cruise_speed  <= bsd_pkg::CRUISE_RESET;
            cfg_reg.near_speed    <= bsd_pkg::NEAR_RESET;
            cfg_reg.search_spin   <= bsd_pkg::SPIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/bsd_frame_stats.sv]
`timescale 1ns / 1ps
// ============================================================================
// bsd_frame_stats: frame sum and brightest sensor
// Adds the eight samples and picks the first maximum.
// ============================================================================
module bsd_frame_stats (
    input  bsd_pkg::frame_t  frame,
    output bsd_pkg::stats_t  stats
);

    logic [bsd_pkg::SUM_BITS-1:0]    sum;
    logic [bsd_pkg::SAMPLE_BITS-1:0] best;
    logic [bsd_pkg::IDX_BITS-1:0]    best_idx;

    always_comb
    begin
        sum      = bsd_pkg::SUM_BITS'(frame[0]);
        best     = frame[0];
        best_idx = '0;
        for (int i = 1; i < bsd_pkg::SENSOR_COUNT; i++)
        begin
            sum = sum + bsd_pkg::SUM_BITS'(frame[i]);
            // strict compare keeps the earliest on a tie
            if (frame[i] > best)
            begin
                best     = frame[i];
                best_idx = bsd_pkg::IDX_BITS'(i);
            end
        end
    end

    assign stats.total = sum;
    assign stats.index = best_idx;

endmodule

[design/bsd_drive_calc.sv]
`timescale 1ns / 1ps
// ============================================================================
// bsd_drive_calc: mode select and motor commands
// Heading error times gain, level tests, then saturated left/right drive.
// ============================================================================
module bsd_drive_calc (
    input  bsd_pkg::cfg_t    regs,
    input  bsd_pkg::stats_t  stats,
    output bsd_pkg::result_t res
);

    localparam int CB = bsd_pkg::CALC_BITS;

    function automatic logic signed [bsd_pkg::DRIVE_BITS-1:0] sat_drive(
        input logic signed [bsd_pkg::CALC_BITS-1:0] v
    );
        logic signed [bsd_pkg::CALC_BITS-1:0] c;
        begin
            if (v > bsd_pkg::DRIVE_MAX)
                c = bsd_pkg::DRIVE_MAX;
            else if (v < bsd_pkg::DRIVE_MIN)
                c = bsd_pkg::DRIVE_MIN;
            else
                c = v;
            return c[bsd_pkg::DRIVE_BITS-1:0];
        end
    endfunction

    logic signed [bsd_pkg::ERR_BITS-1:0] heading_err;
    logic signed [CB-1:0]                err_ext;
    logic signed [CB-1:0]                gain_ext;
    logic signed [CB-1:0]                steer;
    logic signed [CB-1:0]                speed;
    logic signed [CB-1:0]                left_sum;
    logic signed [CB-1:0]                right_sum;
    logic                                hit_search;
    logic                                hit_near;
    logic                                hit_stop;
    bsd_pkg::drive_mode_t                mode;

    assign heading_err = $signed({1'b0, bsd_pkg::CENTER_SENSOR})
                       - $signed({1'b0, stats.index});
    assign err_ext  = {{(CB - bsd_pkg::ERR_BITS){heading_err[bsd_pkg::ERR_BITS-1]}},
                       heading_err};
    assign gain_ext = $signed({{(CB - bsd_pkg::GAIN_BITS){1'b0}}, regs.steer_gain});

    assign hit_search = stats.total < regs.dark_thresh;
    assign hit_near   = stats.total > regs.near_thresh;
    assign hit_stop   = stats.total > regs.halt_thresh;

    always_comb
    begin
        steer = err_ext * gain_ext;
        speed = $signed({{(CB - bsd_pkg::GAIN_BITS){1'b0}}, regs.cruise_speed});
        mode  = bsd_pkg::MODE_TRACK;
        if (hit_search)
        begin
            speed = '0;
            steer = -$signed({{(CB - bsd_pkg::GAIN_BITS){1'b0}}, regs.search_spin});
            mode  = bsd_pkg::MODE_SEARCH;
        end
        // near keeps whatever steer stands
        if (hit_near)
        begin
            speed = $signed({{(CB - bsd_pkg::GAIN_BITS){1'b0}}, regs.near_speed});
            mode  = bsd_pkg::MODE_NEAR;
        end
        if (hit_stop)
        begin
            speed = '0;
            steer = '0;
            mode  = bsd_pkg::MODE_STOP;
        end
    end

    assign left_sum  = steer + speed;
    assign right_sum = steer - speed;

    assign res.left_drive      = sat_drive(left_sum);
    assign res.right_drive     = sat_drive(right_sum);
    assign res.total_intensity = stats.total;
    assign res.brightest_index = stats.index;
    assign res.drive_mode      = mode;

endmodule

[design/beacon_steering_drive_top.sv]
`timescale 1ns / 1ps
`include "beacon_steering_drive_top_macros.svh"
// ============================================================================
// beacon_steering_drive_top: infrared beacon homing drive
// Turns one frame of eight photodiode readings into left/right motor commands.
// ============================================================================
// One frame per clock in, one result word per frame out. Each frame is
// captured in an input register, passes once through the sum / brightest
// sensor / steering logic and lands in a result register, so a word comes
// out of the result register, and a new frame can be taken in
// every cycle while the result side keeps up. The result register parts the
// two sides: a new frame is taken while a finished word waits, and the two
// stages only hold when both are full and the sink is stalled. Registers
// are written through the cfg channel, which is always ready; write them
// only while no frame is in flight. Reset values: ambient 200, slow 5000,
// stop 6000, gain 20, cruise 70, near 40, spin 45.
module beacon_steering_drive_top (
    input  logic           clk,
    input  logic           rst_n,
    bsd_frame_if.sink      frame,
    bsd_result_if.source   result,
    bsd_cfg_if.sink        cfg
);

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    bsd_pkg::cfg_t regs;

    bsd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // ------------------------------------------------------------------
    // Pipeline control: stage 1 is the input register, stage 2 the
    // result register. Stage 2 moves when empty or drained; stage 1
    // refills when empty or moving into stage 2.
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic in_valid_next;
    logic res_valid_reg;
    logic res_valid_next;
    logic advance;
    logic take_frame;

    assign advance     = !res_valid_reg || result.ready;
    assign frame.ready = !in_valid_reg || advance;
    assign take_frame  = frame.valid && frame.ready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        res_valid_next = res_valid_reg;
        if (frame.ready)
            in_valid_next = frame.valid;
        if (advance)
            res_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register (payload, no reset)
    // ------------------------------------------------------------------
    bsd_pkg::frame_t frame_reg;

    always_ff @(posedge clk)
    begin
        if (take_frame)
        begin
            frame_reg[0] <= frame.intensity_0;
            frame_reg[1] <= frame.intensity_1;
            frame_reg[2] <= frame.intensity_2;
            frame_reg[3] <= frame.intensity_3;
            frame_reg[4] <= frame.intensity_4;
            frame_reg[5] <= frame.intensity_5;
            frame_reg[6] <= frame.intensity_6;
            frame_reg[7] <= frame.intensity_7;
        end
    end

    // ------------------------------------------------------------------
    // Single combinational pass
    // ------------------------------------------------------------------
    bsd_pkg::stats_t  stats;
    bsd_pkg::result_t res_calc;

    bsd_frame_stats u_frame_stats (
        .frame (frame_reg),
        .stats (stats)
    );

    bsd_drive_calc u_drive_calc (
        .regs  (regs),
        .stats (stats),
        .res   (res_calc)
    );

    // ------------------------------------------------------------------
    // Result register (payload, no reset)
    // ------------------------------------------------------------------
    bsd_pkg::result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            result_reg <= res_calc;
    end

    assign result.valid           = res_valid_reg;
    assign result.left_drive      = result_reg.left_drive;
    assign result.right_drive     = result_reg.right_drive;
    assign result.total_intensity = result_reg.total_intensity;
    assign result.brightest_index = result_reg.brightest_index;
    assign result.drive_mode      = result_reg.drive_mode;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // stopped: both motors off
    `BSD_ASSERT_IMP(a_stop_zero, result.valid && result.drive_mode == bsd_pkg::MODE_STOP, result.left_drive == 0 && result.right_drive == 0, "stop mode with nonzero drive")
    // searching: pure spin, both sides equal
    `BSD_ASSERT_IMP(a_search_spin, result.valid && result.drive_mode == bsd_pkg::MODE_SEARCH, result.left_drive == result.right_drive, "search mode with forward speed")
    // saturation never reaches -128
    `BSD_ASSERT_IMP(a_sat_range, result.valid, result.left_drive != -8'sd128 && result.right_drive != -8'sd128, "drive outside +-127")
    // a held frame is not lost while stage 2 is stalled
    `BSD_ASSERT_NXT(a_stage1_hold, in_valid_reg && !advance, in_valid_reg && res_valid_reg, "stage 1 frame dropped during stall")

endmodule

[tb/sv/beacon_steering_drive_top_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// beacon_steering_drive_top_tb: self-checking bench for the beacon drive
// Drives sensor frames and register writes over valid/ready channels, predicts
// every drive word from a local model of the steering rules and compares the
// words that come out, field by field, in order.
// ============================================================================
module beacon_steering_drive_top_tb;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 5;
    localparam int HOLD_CYCLES  = 300;    // long sink stall to back the block up
    localparam int DRAIN_CYCLES = 4;      // two-stage pipe plus margin
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_SAMPLE   = (1 << bsd_pkg::SAMPLE_BITS) - 1;
    localparam int MAX_TOTAL    = bsd_pkg::SENSOR_COUNT * MAX_SAMPLE;
    localparam int PAD_BITS     = bsd_pkg::CFG_DATA_BITS - bsd_pkg::GAIN_BITS;

    // Index past the last register; writes to it must be dropped.
    localparam logic [bsd_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 3'd7;

    // ------------------------------------------------------------------------
    // Drive word tracker: keeps a copy of the registers, predicts one word per
    // accepted frame and checks the words in arrival order.
    // ------------------------------------------------------------------------
    class drive_scoreboard;
        bsd_pkg::cfg_t    regs;
        bsd_pkg::result_t drive_words[$];
        int               mismatch_count;

        function new();
            regs.dark_thresh   = bsd_pkg::AMBIENT_RESET;
            regs.near_thresh   = bsd_pkg::SLOW_RESET;
            regs.halt_thresh   = bsd_pkg::STOP_RESET;
            regs.steer_gain    = bsd_pkg::GAIN_RESET;
            regs.cruise_speed  = bsd_pkg::CRUISE_RESET;
            regs.near_speed    = bsd_pkg::NEAR_RESET;
            regs.search_spin   = bsd_pkg::SPIN_RESET;
            mismatch_count     = 0;
        endfunction

        // Gain registers keep only their low bits; unknown indexes do nothing.
        function void write_reg(logic [bsd_pkg::CFG_INDEX_BITS-1:0] idx,
                                logic [bsd_pkg::CFG_DATA_BITS-1:0] data);
            case (idx)
                bsd_pkg::CFG_AMBIENT: regs.dark_thresh  = data[bsd_pkg::LEVEL_BITS-1:0];
                bsd_pkg::CFG_SLOW:    regs.near_thresh  = data[bsd_pkg::LEVEL_BITS-1:0];
                bsd_pkg::CFG_STOP:    regs.halt_thresh  = data[bsd_pkg::LEVEL_BITS-1:0];
                bsd_pkg::CFG_GAIN:    regs.steer_gain   = data[bsd_pkg::GAIN_BITS-1:0];
                bsd_pkg::CFG_CRUISE:  regs.cruise_speed = data[bsd_pkg::GAIN_BITS-1:0];
                bsd_pkg::CFG_NEAR:    regs.near_speed   = data[bsd_pkg::GAIN_BITS-1:0];
                bsd_pkg::CFG_SPIN:    regs.search_spin  = data[bsd_pkg::GAIN_BITS-1:0];
                default:     ;
            endcase
        endfunction

        function int clamp_drive(int v);
            if (v > int'(bsd_pkg::DRIVE_MAX))
            begin
                return int'(bsd_pkg::DRIVE_MAX);
            end
            if (v < int'(bsd_pkg::DRIVE_MIN))
            begin
                return int'(bsd_pkg::DRIVE_MIN);
            end
            return v;
        endfunction

        function bsd_pkg::result_t predict_drive(bsd_pkg::frame_t f);
            int                   total;
            int                   peak;
            int                   idx;
            int                   steer;
            int                   speed;
            bsd_pkg::drive_mode_t mode;
            bsd_pkg::result_t     word;
            total = 0;
            peak  = 0;
            idx   = 0;
            for (int i = 0; i < bsd_pkg::SENSOR_COUNT; i++)
            begin
                total += int'(f[i]);
                // strict compare: first maximum wins
                if (i == 0 || int'(f[i]) > peak)
                begin
                    peak = int'(f[i]);
                    idx  = i;
                end
            end
            steer = (int'(bsd_pkg::CENTER_SENSOR) - idx) * int'(regs.steer_gain);
            speed = int'(regs.cruise_speed);
            mode  = bsd_pkg::MODE_TRACK;
            // each level test overrides the mode and speed set before it
            if (total < int'(regs.dark_thresh))
            begin
                speed = 0;
                steer = -int'(regs.search_spin);
                mode  = bsd_pkg::MODE_SEARCH;
            end
            if (total > int'(regs.near_thresh))
            begin
                speed = int'(regs.near_speed);
                mode  = bsd_pkg::MODE_NEAR;
            end
            if (total > int'(regs.halt_thresh))
            begin
                speed = 0;
                steer = 0;
                mode  = bsd_pkg::MODE_STOP;
            end
            word.left_drive      = bsd_pkg::DRIVE_BITS'(clamp_drive(steer + speed));
            word.right_drive     = bsd_pkg::DRIVE_BITS'(clamp_drive(steer - speed));
            word.total_intensity = bsd_pkg::SUM_BITS'(total);
            word.brightest_index = bsd_pkg::IDX_BITS'(idx);
            word.drive_mode      = mode;
            return word;
        endfunction

        function void note_frame(bsd_pkg::frame_t f);
            drive_words.push_back(predict_drive(f));
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_word(bsd_pkg::result_t got);
            bsd_pkg::result_t want;
            if (drive_words.size() == 0)
            begin
                $error("drive word arrived with no frame outstanding");
                mismatch_count++;
                return;
            end
            want = drive_words.pop_front();
            compare_field("left_drive", want.left_drive, got.left_drive);
            compare_field("right_drive", want.right_drive, got.right_drive);
            compare_field("total_intensity", want.total_intensity, got.total_intensity);
            compare_field("brightest_index", want.brightest_index, got.brightest_index);
            compare_field("drive_mode", want.drive_mode, got.drive_mode);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    int   hold_reqs;         // long stalls asked of the sink process
    int   holds_done;        // long stalls the sink process has started
    int   src_idle_pct;      // chance per cycle that the frame side idles
    int   sink_idle_pct;     // chance per cycle that the result side stalls
    int   cycle_count;

    drive_scoreboard  sb;
    bsd_pkg::frame_t  bus_frame;
    bsd_pkg::result_t bus_word;

    bsd_frame_if  frame_if ();
    bsd_result_if result_if ();
    bsd_cfg_if    cfg_if ();

    beacon_steering_drive_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor. Everything the bench drives changes on the falling edge, so at
    // the rising edge the channel values are settled and the block's own
    // registers still hold their pre-edge values.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                bus_word.left_drive      = result_if.left_drive;
                bus_word.right_drive     = result_if.right_drive;
                bus_word.total_intensity = result_if.total_intensity;
                bus_word.brightest_index = result_if.brightest_index;
                bus_word.drive_mode      = bsd_pkg::drive_mode_t'(result_if.drive_mode);
                sb.check_word(bus_word);
            end
            if (frame_if.valid && frame_if.ready)
            begin
                bus_frame[0] = frame_if.intensity_0;
                bus_frame[1] = frame_if.intensity_1;
                bus_frame[2] = frame_if.intensity_2;
                bus_frame[3] = frame_if.intensity_3;
                bus_frame[4] = frame_if.intensity_4;
                bus_frame[5] = frame_if.intensity_5;
                bus_frame[6] = frame_if.intensity_6;
                bus_frame[7] = frame_if.intensity_7;
                sb.note_frame(bus_frame);
            end
            // writes only happen with the pipe empty, so order here is moot
            if (cfg_if.valid && cfg_if.ready)
            begin
                sb.write_reg(cfg_if.index, cfg_if.data);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side backpressure. Random stalls per cycle, plus one long stall
    // per request that this process counts out itself while the frame side
    // keeps offering words, so both stages fill and the input stalls.
    // ------------------------------------------------------------------------
    initial
    begin
        result_if.ready = 1'b0;
        holds_done      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != holds_done)
            begin
                result_if.ready <= 1'b0;
                holds_done++;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                result_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Frame helpers
    // ------------------------------------------------------------------------
    function automatic bsd_pkg::frame_t flat_frame(int v);
        bsd_pkg::frame_t f;
        for (int i = 0; i < bsd_pkg::SENSOR_COUNT; i++)
        begin
            f[i] = bsd_pkg::SAMPLE_BITS'(v);
        end
        return f;
    endfunction

    // Mix of frame shapes: plain random, dim (search), bright (stop), one
    // clear peak, forced ties, and totals placed right at a current level.
    function automatic bsd_pkg::frame_t random_frame();
        bsd_pkg::frame_t f;
        int              v [bsd_pkg::SENSOR_COUNT];
        int              style;
        int              level;
        int              target;
        int              a;
        int              b;
        int              lim;
        int              top;
        style = $urandom_range(0, 9);
        for (int i = 0; i < bsd_pkg::SENSOR_COUNT; i++)
        begin
            v[i] = $urandom_range(0, MAX_SAMPLE);
        end
        case (style)
            3:
            begin
                for (int i = 0; i < bsd_pkg::SENSOR_COUNT; i++)
                begin
                    v[i] = $urandom_range(0, 40);
                end
            end
            4:
            begin
                for (int i = 0; i < bsd_pkg::SENSOR_COUNT; i++)
                begin
                    v[i] = $urandom_range(850, MAX_SAMPLE);
                end
            end
            5, 6:
            begin
                for (int i = 0; i < bsd_pkg::SENSOR_COUNT; i++)
                begin
                    v[i] = $urandom_range(0, 300);
                end
                v[$urandom_range(0, bsd_pkg::SENSOR_COUNT - 1)] =
                    $urandom_range(700, MAX_SAMPLE);
            end
            7:
            begin
                top = $urandom_range(0, MAX_SAMPLE);
                for (int i = 0; i < bsd_pkg::SENSOR_COUNT; i++)
                begin
                    v[i] = $urandom_range(0, top);
                end
                v[$urandom_range(0, bsd_pkg::SENSOR_COUNT - 1)] = top;
                v[$urandom_range(0, bsd_pkg::SENSOR_COUNT - 1)] = top;
            end
            8, 9:
            begin
                case ($urandom_range(0, 2))
                    0:       level = int'(sb.regs.dark_thresh);
                    1:       level = int'(sb.regs.near_thresh);
                    default: level = int'(sb.regs.halt_thresh);
                endcase
                target = level + int'($urandom_range(0, 4)) - 2;
                if (target < 0)
                begin
                    target = 0;
                end
                if (target > MAX_TOTAL)
                begin
                    target = MAX_TOTAL;
                end
                for (int i = 0; i < bsd_pkg::SENSOR_COUNT; i++)
                begin
                    v[i] = target / bsd_pkg::SENSOR_COUNT
                         + ((i < target % bsd_pkg::SENSOR_COUNT) ? 1 : 0);
                end
                // shift intensity between sensors, total unchanged
                for (int k = 0; k < 2; k++)
                begin
                    a   = $urandom_range(0, bsd_pkg::SENSOR_COUNT - 1);
                    b   = $urandom_range(0, bsd_pkg::SENSOR_COUNT - 1);
                    lim = (v[a] < MAX_SAMPLE - v[b]) ? v[a] : MAX_SAMPLE - v[b];
                    top = $urandom_range(0, lim);
                    v[a] -= top;
                    v[b] += top;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < bsd_pkg::SENSOR_COUNT; i++)
        begin
            f[i] = bsd_pkg::SAMPLE_BITS'(v[i]);
        end
        return f;
    endfunction

    function automatic bsd_pkg::cfg_t make_settings(int amb, int slow, int stop, int gain,
                                                    int cruise, int near_spd, int spin);
        bsd_pkg::cfg_t s;
        s.dark_thresh   = bsd_pkg::LEVEL_BITS'(amb);
        s.near_thresh   = bsd_pkg::LEVEL_BITS'(slow);
        s.halt_thresh   = bsd_pkg::LEVEL_BITS'(stop);
        s.steer_gain    = bsd_pkg::GAIN_BITS'(gain);
        s.cruise_speed  = bsd_pkg::GAIN_BITS'(cruise);
        s.near_speed    = bsd_pkg::GAIN_BITS'(near_spd);
        s.search_spin   = bsd_pkg::GAIN_BITS'(spin);
        return s;
    endfunction

    // Mostly ordered levels so all four modes show up; sometimes anything.
    function automatic bsd_pkg::cfg_t random_settings();
        bsd_pkg::cfg_t s;
        if ($urandom_range(0, 3) == 0)
        begin
            s.dark_thresh = bsd_pkg::LEVEL_BITS'($urandom);
            s.near_thresh = bsd_pkg::LEVEL_BITS'($urandom);
            s.halt_thresh = bsd_pkg::LEVEL_BITS'($urandom);
        end
        else
        begin
            s.dark_thresh = bsd_pkg::LEVEL_BITS'($urandom_range(0, 3000));
            s.near_thresh = bsd_pkg::LEVEL_BITS'($urandom_range(3000, 6500));
            s.halt_thresh = bsd_pkg::LEVEL_BITS'($urandom_range(5000, 8191));
        end
        s.steer_gain   = bsd_pkg::GAIN_BITS'($urandom);
        s.cruise_speed = bsd_pkg::GAIN_BITS'($urandom);
        s.near_speed   = bsd_pkg::GAIN_BITS'($urandom);
        s.search_spin  = bsd_pkg::GAIN_BITS'($urandom);
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. All tasks start and end on a falling edge. Valid is left high
    // between back-to-back words so it is assigned once per time step.
    // ------------------------------------------------------------------------
    task automatic send_frame(input bsd_pkg::frame_t f);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            frame_if.valid <= 1'b0;
            @(negedge clk);
        end
        frame_if.valid       <= 1'b1;
        frame_if.intensity_0 <= f[0];
        frame_if.intensity_1 <= f[1];
        frame_if.intensity_2 <= f[2];
        frame_if.intensity_3 <= f[3];
        frame_if.intensity_4 <= f[4];
        frame_if.intensity_5 <= f[5];
        frame_if.intensity_6 <= f[6];
        frame_if.intensity_7 <= f[7];
        do @(posedge clk); while (!frame_if.ready);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_frame(random_frame());
        end
    endtask

    // One bright sensor over a flat floor, at each position in turn.
    task automatic send_peak_sweep();
        bsd_pkg::frame_t f;
        for (int i = 0; i < bsd_pkg::SENSOR_COUNT; i++)
        begin
            f    = flat_frame(100);
            f[i] = bsd_pkg::SAMPLE_BITS'(900);
            send_frame(f);
        end
    endtask

    task automatic write_reg(input logic [bsd_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [bsd_pkg::CFG_DATA_BITS-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
    endtask

    // Gain words carry random junk above their width; the unused index is
    // written last so anything it clobbers would show up.
    task automatic load_settings(input bsd_pkg::cfg_t s);
        write_reg(bsd_pkg::CFG_AMBIENT, s.dark_thresh);
        write_reg(bsd_pkg::CFG_SLOW, s.near_thresh);
        write_reg(bsd_pkg::CFG_STOP, s.halt_thresh);
        write_reg(bsd_pkg::CFG_GAIN, {PAD_BITS'($urandom), s.steer_gain});
        write_reg(bsd_pkg::CFG_CRUISE, {PAD_BITS'($urandom), s.cruise_speed});
        write_reg(bsd_pkg::CFG_NEAR, {PAD_BITS'($urandom), s.near_speed});
        write_reg(bsd_pkg::CFG_SPIN, {PAD_BITS'($urandom), s.search_spin});
        write_reg(CFG_UNUSED, bsd_pkg::CFG_DATA_BITS'($urandom));
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and wait for every outstanding word, then a few more cycles
    // so the pipe is known empty before registers change.
    task automatic settle();
        frame_if.valid <= 1'b0;
        while (sb.drive_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bsd_pkg::frame_t f;
        sb                   = new();
        rst_n                = 1'b0;
        hold_reqs            = 0;
        src_idle_pct         = 26;
        sink_idle_pct        = 57;
        frame_if.valid       = 1'b0;
        frame_if.intensity_0 = '0;
        frame_if.intensity_1 = '0;
        frame_if.intensity_2 = '0;
        frame_if.intensity_3 = '0;
        frame_if.intensity_4 = '0;
        frame_if.intensity_5 = '0;
        frame_if.intensity_6 = '0;
        frame_if.intensity_7 = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- reset settings: ambient 200, slow 5000, stop 6000 ---
        send_frame(flat_frame(0));              // dark: search
        send_frame(flat_frame(MAX_SAMPLE));     // full scale: stop
        send_frame(flat_frame('h2AA));          // alternating bits, near
        send_frame(flat_frame('h155));          // alternating bits, track
        send_frame(flat_frame(512));            // all tied, index 0 wins
        f    = flat_frame(10);                  // tie between 3 and 6
        f[3] = bsd_pkg::SAMPLE_BITS'(600);
        f[6] = bsd_pkg::SAMPLE_BITS'(600);
        send_frame(f);
        // totals on either side of each level
        f    = flat_frame(0);
        f[0] = bsd_pkg::SAMPLE_BITS'(199);
        send_frame(f);
        f[0] = bsd_pkg::SAMPLE_BITS'(200);
        send_frame(f);
        f    = flat_frame(625);
        send_frame(f);
        f[0] = bsd_pkg::SAMPLE_BITS'(626);
        send_frame(f);
        f    = flat_frame(750);
        send_frame(f);
        f[0] = bsd_pkg::SAMPLE_BITS'(751);
        send_frame(f);
        send_peak_sweep();
        // long sink stall while frames keep coming
        hold_reqs++;
        send_random(150);
        settle();

        // --- top gains and speeds; no search, near or stop possible ---
        load_settings(make_settings(0, 8191, 8191, 127, 127, 127, 127));
        send_peak_sweep();                      // steer saturates both ways
        send_random(150);
        settle();

        src_idle_pct  = 57;
        sink_idle_pct = 26;

        // --- overlapping levels: search and near hold together ---
        load_settings(make_settings(8191, 0, 8191, 0, 0, 127, 127));
        send_random(150);
        settle();

        // --- all zero: any light stops, a dark frame tracks at zero ---
        load_settings(make_settings(0, 0, 0, 0, 0, 0, 0));
        send_frame(flat_frame(0));
        send_random(100);
        settle();

        load_settings(random_settings());
        send_random(170);
        settle();

        src_idle_pct  = 0;
        sink_idle_pct = 0;

        load_settings(random_settings());
        hold_reqs++;
        send_random(170);
        settle();

        load_settings(random_settings());
        send_random(170);
        settle();

        load_settings(random_settings());
        send_random(170);
        settle();

        // back to the reset values
        load_settings(make_settings(bsd_pkg::AMBIENT_RESET, bsd_pkg::SLOW_RESET,
                                    bsd_pkg::STOP_RESET, bsd_pkg::GAIN_RESET,
                                    bsd_pkg::CRUISE_RESET, bsd_pkg::NEAR_RESET,
                                    bsd_pkg::SPIN_RESET));
        send_random(150);
        settle();

        if (sb.mismatch_count == 0 && sb.drive_words.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
